// ===== hdl/dmer_pkg.sv =====
// Shared types and constants for the distance matrix edge reduction block.
package dmer_pkg;

  localparam int NODE_COUNT_BITS   = 6;
  localparam int WEIGHT_FIELD_BITS = 20;
  localparam int EDGE_COUNT_BITS   = 9;
  localparam int NODE_BITS         = 6;

  localparam logic [NODE_COUNT_BITS-1:0] NODE_COUNT_RESET = 6'd32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EDGE   = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic [WEIGHT_FIELD_BITS-1:0] weight;
  } req_t;

  typedef struct packed {
    logic                         kind;
    logic                         consistent;
    logic [EDGE_COUNT_BITS-1:0]   edge_count;
    logic [NODE_BITS-1:0]         node_a;
    logic [NODE_BITS-1:0]         node_b;
    logic [WEIGHT_FIELD_BITS-1:0] edge_weight;
    logic                         last_edge;
  } rsp_t;

endpackage

// ===== hdl/distance_matrix_edge_reduction.sv =====
// Distance matrix edge reduction: weight store, triangle check sequencer and edge readout.

// Load items write one lower-triangle weight each. The load item that completes the matrix
// starts the triangle check, which runs one shared adder and comparator over all triples
// with a two-port read of the weight memory: each pair (i,j) fetches d(i,j), skips k = i
// and k = j, reads and tests d(i,k) + d(k,j) for every other k, and closes by writing the
// pair's keep bit; after the last pair the status item is issued. A fetch item scans the
// keep map pair by pair from where the previous fetch stopped, and returns when the next
// kept edge is handed to the output register. The block takes no new item while a check or
// a scan runs; a load that does not complete the matrix and a fetch with an empty list
// finish without leaving the idle state. A finished item waits in the output register
// while the next input item is taken. Writing node_count restarts loading at row 1 and
// drops any pending edge list.
module distance_matrix_edge_reduction import dmer_pkg::*; #(
  parameter int MAX_NODES   = 32,
  parameter int WEIGHT_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  req_t                       req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output rsp_t                       rsp,
  input  logic                       cfg_wr_en,
  input  logic [NODE_COUNT_BITS-1:0] cfg_wr_data
);

  localparam int NB = $clog2(MAX_NODES);
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int AW = 2 * NB;
  localparam int SW = (WEIGHT_BITS < WEIGHT_FIELD_BITS) ? WEIGHT_BITS : WEIGHT_FIELD_BITS;
  localparam int CW = $clog2(MAX_NODES * (MAX_NODES - 1) / 2 + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PAIR, S_PAIR_WAIT, S_K_RD, S_K_CMP, S_STATUS, S_F_RD, S_F_CHK
  } state_t;

  state_t                     state;
  logic [NODE_COUNT_BITS-1:0] node_count;
  logic [NW-1:0]              n_eff;
  logic [NW-1:0]              row, col;
  logic [NW-1:0]              ci, cj, k;
  logic [NW-1:0]              fi, fj;
  logic [SW-1:0]              dij;
  logic                       keep;
  logic                       cons;
  logic [CW-1:0]              count;
  logic [CW-1:0]              total;
  logic [CW-1:0]              remaining;

  // weight memory and keep map
  logic [SW-1:0] dist_mem [2**AW];
  logic          keep_mem [2**AW];
  logic [SW-1:0] rd_a, rd_b;
  logic          keep_rd;

  logic          mem_we;
  logic          rd_en_a, rd_en_b;
  logic [AW-1:0] addr_a, addr_b;
  logic          keep_we, keep_re;

  logic          req_accept;
  logic          out_free;
  logic          rsp_load;
  logic [SW:0]   sum;

  function automatic logic [AW-1:0] pair_addr(input logic [NW-1:0] a, input logic [NW-1:0] b);
    pair_addr = (a > b) ? {a[NB-1:0], b[NB-1:0]} : {b[NB-1:0], a[NB-1:0]};
  endfunction

  // clamp the register into the supported node range
  always_comb begin
    if (node_count < NODE_COUNT_BITS'(2)) begin
      n_eff = NW'(2);
    end else if (int'(node_count) > MAX_NODES) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(node_count);
    end
  end

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign sum        = {1'b0, rd_a} + {1'b0, rd_b};
  assign rsp_load   = !cfg_wr_en && out_free &&
                      ((state == S_STATUS) || (state == S_F_CHK && keep_rd));

  always_comb begin
    mem_we  = 1'b0;
    rd_en_a = 1'b0;
    rd_en_b = 1'b0;
    addr_a  = pair_addr(cj, ci);
    addr_b  = pair_addr(k, cj);
    keep_we = 1'b0;
    keep_re = 1'b0;
    unique case (state)
      S_IDLE: begin
        mem_we = req_accept && (req.cmd == CMD_LOAD);
      end
      S_PAIR: begin
        rd_en_a = 1'b1;
      end
      S_K_RD: begin
        if (k == n_eff) begin
          keep_we = 1'b1;
        end else if (k != ci && k != cj) begin
          rd_en_a = 1'b1;
          rd_en_b = 1'b1;
          addr_a  = pair_addr(ci, k);
        end
      end
      S_F_RD: begin
        rd_en_a = 1'b1;
        keep_re = 1'b1;
        addr_a  = pair_addr(fj, fi);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dist_mem[{row[NB-1:0], col[NB-1:0]}] <= req.weight[SW-1:0];
    end
    if (rd_en_a) begin
      rd_a <= dist_mem[addr_a];
    end
    if (rd_en_b) begin
      rd_b <= dist_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (keep_we) begin
      keep_mem[{ci[NB-1:0], cj[NB-1:0]}] <= keep;
    end
    if (keep_re) begin
      keep_rd <= keep_mem[{fi[NB-1:0], fj[NB-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= NODE_COUNT_RESET;
      row        <= NW'(1);
      col        <= '0;
      cons       <= 1'b0;
      remaining  <= '0;
      total      <= '0;
      fi         <= '0;
      fj         <= NW'(1);
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        // a register write restarts loading and drops the edge list
        node_count <= cfg_wr_data;
        row        <= NW'(1);
        col        <= '0;
        remaining  <= '0;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (req_accept) begin
              if (req.cmd == CMD_LOAD) begin
                remaining <= '0;
                if (col + NW'(1) < row) begin
                  col <= col + NW'(1);
                end else begin
                  col <= '0;
                  if (row + NW'(1) < n_eff) begin
                    row <= row + NW'(1);
                  end else begin
                    // matrix complete: start the check at pair (0,1)
                    row   <= NW'(1);
                    ci    <= '0;
                    cj    <= NW'(1);
                    cons  <= 1'b1;
                    count <= '0;
                    state <= S_PAIR;
                  end
                end
              end else if (req.cmd == CMD_FETCH && remaining != '0) begin
                state <= S_F_RD;
              end
            end
          end
          S_PAIR: begin
            k     <= '0;
            keep  <= 1'b1;
            state <= S_PAIR_WAIT;
          end
          S_PAIR_WAIT: begin
            dij   <= rd_a;
            state <= S_K_RD;
          end
          S_K_RD: begin
            if (k == n_eff) begin
              count <= count + CW'(keep);
              if (cj + NW'(1) < n_eff) begin
                cj    <= cj + NW'(1);
                state <= S_PAIR;
              end else if (ci + NW'(2) < n_eff) begin
                ci    <= ci + NW'(1);
                cj    <= ci + NW'(2);
                state <= S_PAIR;
              end else begin
                state <= S_STATUS;
              end
            end else if (k == ci || k == cj) begin
              k <= k + NW'(1);
            end else begin
              state <= S_K_CMP;
            end
          end
          S_K_CMP: begin
            if (sum < {1'b0, dij}) begin
              cons <= 1'b0;
            end
            if (sum == {1'b0, dij}) begin
              keep <= 1'b0;
            end
            k     <= k + NW'(1);
            state <= S_K_RD;
          end
          S_STATUS: begin
            if (out_free) begin
              rsp.kind        <= KIND_STATUS;
              rsp.consistent  <= cons;
              rsp.edge_count  <= cons ? EDGE_COUNT_BITS'(count) : '0;
              rsp.node_a      <= '0;
              rsp.node_b      <= '0;
              rsp.edge_weight <= '0;
              rsp.last_edge   <= 1'b0;
              total           <= cons ? count : '0;
              remaining       <= cons ? count : '0;
              fi              <= '0;
              fj              <= NW'(1);
              state           <= S_IDLE;
            end
          end
          S_F_RD: begin
            state <= S_F_CHK;
          end
          S_F_CHK: begin
            // hold here until the output register frees up for a kept edge
            if (!keep_rd || out_free) begin
              if (fj + NW'(1) < n_eff) begin
                fj <= fj + NW'(1);
              end else begin
                fi <= fi + NW'(1);
                fj <= fi + NW'(2);
              end
              if (!keep_rd) begin
                state <= S_F_RD;
              end else begin
                rsp.kind        <= KIND_EDGE;
                rsp.consistent  <= 1'b1;
                rsp.edge_count  <= EDGE_COUNT_BITS'(total);
                rsp.node_a      <= NODE_BITS'(fi) + NODE_BITS'(1);
                rsp.node_b      <= NODE_BITS'(fj) + NODE_BITS'(1);
                rsp.edge_weight <= WEIGHT_FIELD_BITS'(rd_a);
                rsp.last_edge   <= (remaining == CW'(1));
                remaining       <= remaining - CW'(1);
                state           <= S_IDLE;
              end
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// ===== hdl/dmer_checker.sv =====
// Port-level assertions for the distance matrix edge reduction block, with its bind.
module dmer_checker import dmer_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_edge_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_EDGE |->
      rsp.consistent && rsp.node_a != '0 && rsp.node_a < rsp.node_b)
    else $error("malformed edge item");

  a_status_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_STATUS |->
      rsp.node_a == '0 && rsp.node_b == '0 && rsp.edge_weight == '0 && !rsp.last_edge &&
      (rsp.consistent || rsp.edge_count == '0))
    else $error("malformed status item");

endmodule

bind distance_matrix_edge_reduction dmer_checker u_dmer_checker (.*);
